@@ hw/rtl/kvt_pkg.sv @@
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and constants of the key/value table
// request and response structs, entry count, operation and status codes,
// and the token that walks the row of entry cells
// ----------------------------------------------------------------------------
package kvt_pkg;

  // number of entries in the table
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // request kinds (the unused code behaves as a search)
  localparam logic [1:0] KIND_SEARCH = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  // response status codes
  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_UPDATED = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
    logic [2:0]         status;
  } rsp_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic               act;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               free_seen;
    logic [IDX_W-1:0]   free_idx;
    logic signed [31:0] rd_val;
  } tok_t;

  // commit write broadcast to all cells
  typedef struct packed {
    logic               set_entry;
    logic               set_val;
    logic               clr;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } wr_t;

endpackage

@@ hw/rtl/kvt_cell.sv @@
// ----------------------------------------------------------------------------
// kvt_cell: one entry of the key/value table
// holds key, value and valid bit, checks the passing search token against
// its entry and hands the updated token to the next cell
// ----------------------------------------------------------------------------
module kvt_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [kvt_pkg::IDX_W-1:0] idx_i,
  input  logic signed [31:0]        key_i,
  input  kvt_pkg::wr_t              wr_i,
  input  kvt_pkg::tok_t             tok_i,
  output kvt_pkg::tok_t             tok_o
);
  import kvt_pkg::*;

  logic               valid_q;
  logic signed [31:0] key_q;
  logic signed [31:0] val_q;
  tok_t               tok_d;
  tok_t               tok_q;
  logic               match;
  logic               sel;

  assign match = tok_i.act && valid_q && (key_q == key_i);
  assign sel   = (wr_i.idx == idx_i);

  always_comb begin
    tok_d = tok_i;
    if (match) begin
      tok_d.hit     = 1'b1;
      tok_d.hit_idx = idx_i;
      tok_d.rd_val  = val_q;
    end
    if (tok_i.act && !valid_q && !tok_i.free_seen) begin
      tok_d.free_seen = 1'b1;
      tok_d.free_idx  = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (sel && wr_i.set_entry) begin
        valid_q <= 1'b1;
      end else if (sel && wr_i.clr) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel && wr_i.set_entry) begin
      key_q <= wr_i.key;
    end
    if (sel && (wr_i.set_entry || wr_i.set_val)) begin
      val_q <= wr_i.value;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ hw/rtl/key_value_table_insert_search_delete_top.sv @@
// ----------------------------------------------------------------------------
// key_value_table_insert_search_delete_top: bounded key/value table
// search, insert/update and delete of unique signed 32-bit keys, built as a
// row of entry cells that a search token walks through one cell per cycle
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. busy then stays high
// while the search token walks the row of CAPACITY entry cells, one cell per
// clock, gathering the matching entry and the lowest free entry. In the cycle
// after the token leaves the last cell, the table is updated and the response
// appears on rsp_o for a single cycle with rsp_valid_o high; busy drops in
// that same cycle, so a new request may be taken right then. From acceptance
// to response a request passes the head token register, the CAPACITY cell
// registers and the response register. The receiver cannot stall the
// response: it must capture rsp_o whenever rsp_valid_o is high. After reset
// all entries are empty; no clearing pass is needed.
module key_value_table_insert_search_delete_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  kvt_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output kvt_pkg::rsp_t rsp_o
);
  import kvt_pkg::*;

  // request held for the whole walk
  req_t req_q;
  logic busy_q;
  logic accept;

  // head of the token chain, then one token register per cell
  tok_t tok_head_d;
  tok_t tok_head_q;
  tok_t tok [CAPACITY+1];
  logic [CAPACITY:0] act_vec;

  // commit of the finished walk
  tok_t last;
  wr_t  wr;
  rsp_t rsp_d;
  rsp_t rsp_q;
  logic rsp_valid_q;

  assign accept = start && !busy_q;
  assign last   = tok[CAPACITY];

  // fresh token for a newly taken request
  always_comb begin
    tok_head_d     = '0;
    tok_head_d.act = accept;
  end

  // load a fresh token when a request is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_head_q <= '0;
    end else begin
      tok_head_q <= tok_head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  assign tok[0] = tok_head_q;

  // row of entry cells, each passing the token on to its neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kvt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(i)),
      .key_i  (req_q.key),
      .wr_i   (wr),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  for (genvar j = 0; j <= CAPACITY; j++) begin : g_act
    assign act_vec[j] = tok[j].act;
  end

  // decide the table update and the response once the token leaves the row
  always_comb begin
    wr             = '0;
    wr.key         = req_q.key;
    wr.value       = req_q.value;
    wr.idx         = last.hit ? last.hit_idx : last.free_idx;
    rsp_d          = '0;
    rsp_d.found    = last.hit;
    rsp_d.status   = last.hit ? ST_HIT : ST_ABSENT;
    case (req_q.kind)
      KIND_INSERT: begin
        if (last.hit) begin
          wr.set_val   = last.act;
          rsp_d.status = ST_UPDATED;
        end else if (last.free_seen) begin
          wr.set_entry = last.act;
          rsp_d.status = ST_NEW;
        end else begin
          rsp_d.status = ST_FULL;
        end
      end
      KIND_DELETE: begin
        // delete clears the valid bit of the matching entry only
        wr.clr = last.act && last.hit;
      end
      default: begin
        // search, and the unused kind code behaves the same
        if (last.hit) begin
          rsp_d.read_value = last.rd_val;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= last.act;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (last.act) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last.act) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy        = busy_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef NO_ASSERTIONS
  // only one request is ever in flight along the row
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(act_vec))
    else $error("more than one search token in the cell row");

  // a taken request keeps the block busy until its response
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after a request was taken");

  // busy only drops together with the response strobe
  a_busy_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> rsp_valid_o)
    else $error("busy dropped without a response");

  // a response only follows a request that is in flight
  a_rsp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last.act |-> busy_q)
    else $error("token finished while idle");

  // a miss status (new, full or absent) never comes with found set
  a_new_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status == ST_NEW || rsp_o.status == ST_FULL ||
                     rsp_o.status == ST_ABSENT)) |-> !rsp_o.found)
    else $error("found set on a miss status");
`endif

endmodule

@@ tb/key_value_table_insert_search_delete_top_tb.sv @@
// ----------------------------------------------------------------------------
// key_value_table_insert_search_delete_top_tb: self-checking bench for the
// key/value table
// directed requests cover the empty table, every request kind, the extreme
// keys and the full table; random traffic over a small key pool then keeps
// the table busy with hits, misses, updates and overflows. A shadow table in
// the bench predicts every response, and each response is checked field by
// field in request order.
// ----------------------------------------------------------------------------
module key_value_table_insert_search_delete_top_tb;
  import kvt_pkg::*;

  // the spare kind code is handled as a search
  localparam logic [1:0] KIND_SPARE = 2'd3;
  // cycles with no request taken and no response before the run is abandoned
  localparam int unsigned STALL_LIMIT = 2000;
  // longer than the walk of a request through the table, so this drains any straggler
  localparam int unsigned DRAIN_CYCLES = CAPACITY + 8;
  localparam int unsigned POOL_SIZE = 20;
  localparam int unsigned RANDOM_REQS = 410;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  logic  busy;
  req_t  req_i;
  logic  rsp_valid_o;
  rsp_t  rsp_o;

  // shadow copy of the table contents
  logic signed [31:0] shadow_key [CAPACITY];
  logic signed [31:0] shadow_val [CAPACITY];
  logic               shadow_used [CAPACITY];

  // responses still owed by the table, oldest first
  rsp_t               pending_rsp_q[$];
  int unsigned        taken_cnt;
  int unsigned        quiet_cycles;
  int unsigned        fail_cnt;
  int unsigned        send_idle_pct;
  logic signed [31:0] key_pool [POOL_SIZE];

  key_value_table_insert_search_delete_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // work out the response to one request and update the shadow table
  function automatic rsp_t lookup_and_update(input req_t r);
    rsp_t p;
    int   hit;
    int   free_slot;
    hit = -1;
    free_slot = -1;
    // first valid match and lowest empty entry
    for (int i = 0; i < CAPACITY; i++) begin
      if (shadow_used[i] && shadow_key[i] == r.key && hit < 0) hit = i;
      if (!shadow_used[i] && free_slot < 0) free_slot = i;
    end
    p = '0;
    p.found = (hit >= 0);
    case (r.kind)
      KIND_INSERT: begin
        if (hit >= 0) begin
          shadow_val[hit] = r.value;
          p.status = ST_UPDATED;
        end else if (free_slot >= 0) begin
          shadow_key[free_slot]  = r.key;
          shadow_val[free_slot]  = r.value;
          shadow_used[free_slot] = 1'b1;
          p.status = ST_NEW;
        end else begin
          // new key into a full table leaves it untouched
          p.status = ST_FULL;
        end
      end
      KIND_DELETE: begin
        if (hit >= 0) begin
          shadow_used[hit] = 1'b0;
          p.status = ST_HIT;
        end else begin
          p.status = ST_ABSENT;
        end
      end
      default: begin
        // search, and the spare code behaves the same way
        if (hit >= 0) begin
          p.read_value = shadow_val[hit];
          p.status = ST_HIT;
        end else begin
          p.status = ST_ABSENT;
        end
      end
    endcase
    return p;
  endfunction

  // response check, request capture and stall watchdog, all at the rising edge
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      // check first so a request taken in the response cycle queues behind it
      if (rsp_valid_o) begin
        if (pending_rsp_q.size() == 0) begin
          $error("response with no request outstanding");
          fail_cnt++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp_o.found !== want.found) begin
            $error("found: expected %0d actual %0d", want.found, rsp_o.found);
            fail_cnt++;
          end
          if (rsp_o.read_value !== want.read_value) begin
            $error("read_value: expected %0d actual %0d", want.read_value,
                   rsp_o.read_value);
            fail_cnt++;
          end
          if (rsp_o.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, rsp_o.status);
            fail_cnt++;
          end
        end
      end
      // request taken at this edge
      if (start && !busy) begin
        pending_rsp_q.push_back(lookup_and_update(req_i));
        taken_cnt++;
      end
      // watchdog on forward progress
      if (rsp_valid_o || (start && !busy)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // issue one request and return at the falling edge after it is taken
  task automatic send_req(input logic [1:0] kind, input logic signed [31:0] key,
                          input logic signed [31:0] value);
    int unsigned prev;
    // random idle cycles with start low
    while ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    req_i <= '{kind: kind, key: key, value: value};
    start <= 1'b1;
    prev = taken_cnt;
    wait (taken_cnt != prev);
    @(negedge clk_i);
  endtask

  // empty table, each request kind, extreme keys
  task automatic test_basic_ops();
    send_req(KIND_SEARCH, 32'sh8000_0000, 32'sh1234_5678);  // miss on empty table
    send_req(KIND_INSERT, 32'sh8000_0000, 32'sh7fff_ffff);
    send_req(KIND_INSERT, 32'sh7fff_ffff, 32'sh8000_0000);
    send_req(KIND_INSERT, 32'sh0, 32'sh0);
    send_req(KIND_INSERT, -32'sd1, -32'sd1);
    send_req(KIND_SEARCH, 32'sh8000_0000, 32'sh0);           // hit, value back
    send_req(KIND_SPARE, 32'sh7fff_ffff, 32'sh5555_5555);    // spare code acts as search
    send_req(KIND_INSERT, 32'sh7fff_ffff, 32'sh2aaa_aaaa);   // update in place
    send_req(KIND_DELETE, 32'sd5, 32'sh0);                   // delete of absent key
  endtask

  // fill every entry, overflow, then free an entry and reuse it
  task automatic test_full_table();
    for (int i = 1; i <= CAPACITY - 4; i++) begin
      send_req(KIND_INSERT, i * 7919 + 1, $urandom);
    end
    send_req(KIND_INSERT, 32'sh1357_9bdf, 32'sh1);           // table full
    send_req(KIND_INSERT, -32'sd1, 32'sh0f0f_0f0f);          // update still allowed
    send_req(KIND_DELETE, 32'sh8000_0000, 32'sh0);           // delete hit
    send_req(KIND_INSERT, 32'sh1357_9bdf, 32'sh2);           // lands in freed entry
    send_req(KIND_SEARCH, 32'sh8000_0000, 32'sh0);           // deleted key is gone
  endtask

  // random kinds over a small key pool so hits, deletes and overflows recur
  task automatic test_random_traffic(input int unsigned idle_pct);
    logic [1:0]         kind;
    logic signed [31:0] key;
    int unsigned        roll;
    send_idle_pct = idle_pct;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) kind = KIND_SEARCH;
      else if (roll < 65) kind = KIND_INSERT;
      else if (roll < 92) kind = KIND_DELETE;
      else kind = KIND_SPARE;
      // mostly pool keys, some fully random ones
      if ($urandom_range(0, 99) < 80) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else key = $urandom;
      send_req(kind, key, $urandom);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    taken_cnt = 0;
    quiet_cycles = 0;
    fail_cnt = 0;
    send_idle_pct = 38;
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_key[i] = '0;
      shadow_val[i] = '0;
      shadow_used[i] = 1'b0;
    end
    // pool: extreme keys plus random ones, a few more than the table holds
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = 32'sh0;
    key_pool[3] = -32'sd1;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_basic_ops();
    test_full_table();
    // sender idles often, then more often, then never
    test_random_traffic(38);
    test_random_traffic(59);
    test_random_traffic(0);
    start <= 1'b0;

    // wait for the last response, then a few more cycles for strays
    while (pending_rsp_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/kvt_pkg.sv
hw/rtl/kvt_cell.sv
hw/rtl/key_value_table_insert_search_delete_top.sv
tb/key_value_table_insert_search_delete_top_tb.sv
